[design/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants of the barometric compensation core
// Payload structs, configuration layout, register indexes and helper
// functions for the 32-bit wrapping arithmetic.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OSS    = 3'd0,
        CFG_AC123  = 3'd1,
        CFG_AC456  = 3'd2,
        CFG_B12    = 3'd3,
        CFG_MBMCMD = 3'd4
    } t_cfg_idx;

    // Input beat.
    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic signed [31:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               divide_error;
        logic               calibration_bad;
    } t_out;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [1:0]  oss;
        logic [47:0] ac123;
        logic [47:0] ac456;
        logic [31:0] b12;
        logic [47:0] mbmcmd;
    } t_cfg;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [15:0] ut;
        logic [31:0] up;
    } t_work;

    // Datasheet constants.
    localparam logic [31:0] C_T_OFS  = 32'd4000;
    localparam logic [31:0] C_P_HALF = 32'd32768;
    localparam logic [31:0] C_P_BASE = 32'd50000;
    localparam logic [31:0] C_K1     = 32'd3038;
    localparam logic [31:0] C_K2     = 32'hFFFF_E343;
    localparam logic [31:0] C_K3     = 32'd3791;
    localparam logic [15:0] C_ALL1   = 16'hFFFF;

    // Arithmetic right shift of a 32-bit word.
    function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned n);
        return 32'($signed(v) >>> n);
    endfunction

    // Sign extension of a 16-bit coefficient.
    function automatic logic [31:0] sext16(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    // A calibration word that reads as all zeros or all ones is suspect.
    function automatic logic bad_word(input logic [15:0] w);
        return (w == 16'h0000) || (w == C_ALL1);
    endfunction

endpackage

[design/bsc_front.sv]
// ----------------------------------------------------------------------------
// bsc_front: input side of the compensation core
// Accepts raw beats into a two-entry queue and applies the oversampling
// shift to the pressure reading on the way in.
// ----------------------------------------------------------------------------
module bsc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsc_pkg::t_cfg i_cfg,
    input  logic          push,
    input  bsc_pkg::t_in  i_in_data,
    output logic          full,
    output logic          o_valid,
    output bsc_pkg::t_work o_work,
    input  logic          i_take
);
    import bsc_pkg::*;

    t_work      r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;
    logic [3:0] sh;
    t_work      cls;

    // Classify the incoming beat: pressure is right-aligned by 8 - oss.
    always_comb begin
        sh     = 4'd8 - {2'b00, i_cfg.oss};
        cls.ut = i_in_data.raw_temperature;
        cls.up = {8'h00, i_in_data.raw_pressure} >> sh;
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_mem[r_rp];
    assign wr      = push && !full;
    assign rd      = i_take && o_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= cls;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

[design/bsc_udiv.sv]
// ----------------------------------------------------------------------------
// bsc_udiv: pipelined unsigned restoring divider
// One quotient bit per stage, W stages. A tag travels alongside each beat.
// A zero divisor gives a meaningless quotient that the caller masks.
// ----------------------------------------------------------------------------
module bsc_udiv #(
    parameter int W     = 32,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [W-1:0]     i_dividend,
    input  logic [W-1:0]     i_divisor,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [W-1:0]     o_quot,
    output logic [TAG_W-1:0] o_tag
);
    logic [W-1:0]     r_rem [1:W];
    logic [W-1:0]     r_qd  [1:W];
    logic [W-1:0]     r_dvs [1:W];
    logic [TAG_W-1:0] r_tag [1:W];
    logic             r_v   [1:W];

    logic [W-1:0]     w_rem [0:W-1];
    logic [W-1:0]     w_qd  [0:W-1];
    logic [W-1:0]     w_dvs [0:W-1];
    logic [TAG_W-1:0] w_tag [0:W-1];
    logic             w_v   [0:W-1];

    // Stage inputs: the ports feed the first stage, registers the rest.
    assign w_rem[0] = '0;
    assign w_qd[0]  = i_dividend;
    assign w_dvs[0] = i_divisor;
    assign w_tag[0] = i_tag;
    assign w_v[0]   = i_valid;

    for (genvar k = 1; k < W; k++) begin : g_link
        assign w_rem[k] = r_rem[k];
        assign w_qd[k]  = r_qd[k];
        assign w_dvs[k] = r_dvs[k];
        assign w_tag[k] = r_tag[k];
        assign w_v[k]   = r_v[k];
    end

    for (genvar k = 0; k < W; k++) begin : g_stg
        logic [W:0] trial;
        logic       ge;

        // Shift in the next dividend bit and try the subtraction.
        assign trial = {w_rem[k], w_qd[k][W-1]};
        assign ge    = (trial >= {1'b0, w_dvs[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? W'(trial - {1'b0, w_dvs[k]}) : trial[W-1:0];
                r_qd[k+1]  <= {w_qd[k][W-2:0], ge};
                r_dvs[k+1] <= w_dvs[k];
                r_tag[k+1] <= w_tag[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= w_v[k];
            end
        end
    end

    assign o_valid = r_v[W];
    assign o_quot  = r_qd[W];
    assign o_tag   = r_tag[W];

endmodule

[design/bsc_back.sv]
// ----------------------------------------------------------------------------
// bsc_back: compensation datapath
// Pipelined temperature and pressure formulas with two divider pipelines.
// All stages advance together and hold while the result queue is full and a finished beat is waiting.
// ----------------------------------------------------------------------------
module bsc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsc_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  bsc_pkg::t_work i_work,
    output logic           o_take,
    output logic           o_res_valid,
    output bsc_pkg::t_out  o_res,
    input  logic           i_res_full
);
    import bsc_pkg::*;

    localparam int NA = 3;
    localparam int NB = 8;
    localparam int NC = 3;

    // Everything an item needs on its way through the pipeline.
    typedef struct packed {
        logic [15:0] ut;
        logic [31:0] up;
        logic        calbad;
        logic [31:0] mul;
        logic [31:0] x1;
        logic [31:0] dsr;
        logic [31:0] a;
        logic [31:0] dvd1;
        logic [31:0] dvs1;
        logic        neg;
        logic        dz;
        logic [31:0] b5;
        logic [31:0] temp;
        logic [31:0] b6;
        logic [31:0] sq;
        logic [31:0] mac2;
        logic [31:0] mac3;
        logic [31:0] mb2;
        logic [31:0] mb1;
        logic [31:0] x3a;
        logic [31:0] x3b;
        logic [31:0] b3;
        logic [31:0] s;
        logic [31:0] diff;
        logic [31:0] b4;
        logic [31:0] b7;
        logic        dz2;
        logic [31:0] p;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [31:0] m3;
    } t_ctx;

    localparam int CTX_W = $bits(t_ctx);

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic        calbad;
    logic        adv;

    t_ctx r_a [1:NA];
    t_ctx n_a [1:NA];
    logic r_va [1:NA];
    t_ctx r_b [1:NB];
    t_ctx n_b [1:NB];
    logic r_vb [1:NB];
    t_ctx r_c [1:NC];
    t_ctx n_c [1:NC];
    logic r_vc [1:NC];

    logic             d1_v, d2_v;
    logic [31:0]      d1_q, d2_q;
    logic [CTX_W-1:0] d1_tag, d2_tag;
    t_ctx             d1_ctx, d2_ctx;
    logic [31:0]      d2_dvd;

    // Coefficient decode.
    always_comb begin
        ac1 = sext16(i_cfg.ac123[47:32]);
        ac2 = sext16(i_cfg.ac123[31:16]);
        ac3 = sext16(i_cfg.ac123[15:0]);
        ac4 = {16'h0000, i_cfg.ac456[47:32]};
        ac5 = {16'h0000, i_cfg.ac456[31:16]};
        ac6 = {16'h0000, i_cfg.ac456[15:0]};
        b1  = sext16(i_cfg.b12[31:16]);
        b2  = sext16(i_cfg.b12[15:0]);
        mc  = sext16(i_cfg.mbmcmd[31:16]);
        md  = sext16(i_cfg.mbmcmd[15:0]);
        calbad = bad_word(i_cfg.ac123[47:32]) || bad_word(i_cfg.ac123[31:16])
              || bad_word(i_cfg.ac123[15:0])  || bad_word(i_cfg.ac456[47:32])
              || bad_word(i_cfg.ac456[31:16]) || bad_word(i_cfg.ac456[15:0])
              || bad_word(i_cfg.b12[31:16])   || bad_word(i_cfg.b12[15:0])
              || bad_word(i_cfg.mbmcmd[47:32]) || bad_word(i_cfg.mbmcmd[31:16])
              || bad_word(i_cfg.mbmcmd[15:0]);
    end

    // The whole pipeline holds only when a finished beat cannot leave.
    assign adv    = !(r_vc[NC] && i_res_full);
    assign o_take = adv;

    // Temperature front end up to the first division.
    always_comb begin
        n_a[1]        = '0;
        n_a[1].ut     = i_work.ut;
        n_a[1].up     = i_work.up;
        n_a[1].calbad = calbad;
        n_a[1].mul    = ({16'h0000, i_work.ut} - ac6) * ac5;

        n_a[2]     = r_a[1];
        n_a[2].x1  = sra32(r_a[1].mul, 15);
        n_a[2].dsr = sra32(r_a[1].mul, 15) + md;
        n_a[2].a   = mc << 11;

        n_a[3]      = r_a[2];
        n_a[3].neg  = r_a[2].a[31] ^ r_a[2].dsr[31];
        n_a[3].dvd1 = r_a[2].a[31] ? 32'd0 - r_a[2].a : r_a[2].a;
        n_a[3].dvs1 = r_a[2].dsr[31] ? 32'd0 - r_a[2].dsr : r_a[2].dsr;
        n_a[3].dz   = (r_a[2].dsr == 32'd0);
    end

    bsc_udiv #(.W(32), .TAG_W(CTX_W)) u_div_t (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (r_va[NA]),
        .i_dividend (r_a[NA].dvd1),
        .i_divisor  (r_a[NA].dvs1),
        .i_tag      (r_a[NA]),
        .o_valid    (d1_v),
        .o_quot     (d1_q),
        .o_tag      (d1_tag)
    );

    assign d1_ctx = t_ctx'(d1_tag);

    // Temperature result and pressure terms up to the second division.
    always_comb begin
        logic [31:0] x2;
        logic [31:0] bsq;
        logic [31:0] prod;

        x2        = d1_ctx.dz ? 32'd0 : (d1_ctx.neg ? 32'd0 - d1_q : d1_q);
        n_b[1]    = d1_ctx;
        n_b[1].b5 = d1_ctx.x1 + x2;

        n_b[2]      = r_b[1];
        n_b[2].temp = sra32(r_b[1].b5 + 32'd8, 4);
        n_b[2].b6   = r_b[1].b5 - C_T_OFS;

        n_b[3]      = r_b[2];
        n_b[3].sq   = r_b[2].b6 * r_b[2].b6;
        n_b[3].mac2 = ac2 * r_b[2].b6;
        n_b[3].mac3 = ac3 * r_b[2].b6;

        bsq        = sra32(r_b[3].sq, 12);
        n_b[4]     = r_b[3];
        n_b[4].mb2 = b2 * bsq;
        n_b[4].mb1 = b1 * bsq;

        n_b[5]     = r_b[4];
        n_b[5].x3a = sra32(r_b[4].mb2, 11) + sra32(r_b[4].mac2, 11);
        n_b[5].x3b = sra32(sra32(r_b[4].mac3, 13) + sra32(r_b[4].mb1, 16) + 32'd2, 2);

        n_b[6]    = r_b[5];
        n_b[6].b3 = sra32((((ac1 << 2) + r_b[5].x3a) << i_cfg.oss) + 32'd2, 2);
        n_b[6].s  = r_b[5].x3b + C_P_HALF;

        prod        = ac4 * r_b[6].s;
        n_b[7]      = r_b[6];
        n_b[7].diff = r_b[6].up - r_b[6].b3;
        n_b[7].b4   = prod >> 15;

        n_b[8]     = r_b[7];
        n_b[8].b7  = r_b[7].diff * (C_P_BASE >> i_cfg.oss);
        n_b[8].dz2 = (r_b[7].b4 == 32'd0);
    end

    // Large B7 is divided first and doubled after, small B7 doubled first.
    assign d2_dvd = r_b[NB].b7[31] ? r_b[NB].b7 : (r_b[NB].b7 << 1);

    bsc_udiv #(.W(32), .TAG_W(CTX_W)) u_div_p (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (r_vb[NB]),
        .i_dividend (d2_dvd),
        .i_divisor  (r_b[NB].b4),
        .i_tag      (r_b[NB]),
        .o_valid    (d2_v),
        .o_quot     (d2_q),
        .o_tag      (d2_tag)
    );

    assign d2_ctx = t_ctx'(d2_tag);

    // Pressure correction polynomial.
    always_comb begin
        logic [31:0] a8;

        n_c[1]   = d2_ctx;
        n_c[1].p = d2_ctx.dz2 ? 32'd0 : (d2_ctx.b7[31] ? (d2_q << 1) : d2_q);

        a8        = sra32(r_c[1].p, 8);
        n_c[2]    = r_c[1];
        n_c[2].m1 = a8 * a8;
        n_c[2].m2 = r_c[1].p * C_K2;

        n_c[3]    = r_c[2];
        n_c[3].m3 = r_c[2].m1 * C_K1;
    end

    // Final sum and zero-divisor masking.
    always_comb begin
        logic [31:0] pf;
        logic        derr;

        pf   = r_c[NC].p
             + sra32(sra32(r_c[NC].m3, 16) + sra32(r_c[NC].m2, 16) + C_K3, 4);
        derr = r_c[NC].dz || r_c[NC].dz2;
        o_res.temperature_tenths = derr ? 32'sd0 : $signed(r_c[NC].temp);
        o_res.pressure_pa        = derr ? 32'sd0 : $signed(pf);
        o_res.divide_error       = derr;
        o_res.calibration_bad    = r_c[NC].calbad;
    end

    assign o_res_valid = r_vc[NC];

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 1; i <= NA; i++) begin
                r_a[i] <= n_a[i];
            end
            for (int i = 1; i <= NB; i++) begin
                r_b[i] <= n_b[i];
            end
            for (int i = 1; i <= NC; i++) begin
                r_c[i] <= n_c[i];
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= NA; i++) begin
                r_va[i] <= 1'b0;
            end
            for (int i = 1; i <= NB; i++) begin
                r_vb[i] <= 1'b0;
            end
            for (int i = 1; i <= NC; i++) begin
                r_vc[i] <= 1'b0;
            end
        end else if (adv) begin
            r_va[1] <= i_valid;
            for (int i = 2; i <= NA; i++) begin
                r_va[i] <= r_va[i-1];
            end
            r_vb[1] <= d1_v;
            for (int i = 2; i <= NB; i++) begin
                r_vb[i] <= r_vb[i-1];
            end
            r_vc[1] <= d2_v;
            for (int i = 2; i <= NC; i++) begin
                r_vc[i] <= r_vc[i-1];
            end
        end
    end

endmodule

[design/bsc_outq.sv]
// ----------------------------------------------------------------------------
// bsc_outq: result queue
// Two-entry queue between the datapath and the result side.
// ----------------------------------------------------------------------------
module bsc_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  bsc_pkg::t_out i_item,
    output logic          o_full,
    output logic          empty,
    input  logic          pop,
    output bsc_pkg::t_out o_item
);
    import bsc_pkg::*;

    t_out       r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_full = (r_cnt == 2'd2);
    assign empty  = (r_cnt == 2'd0);
    assign o_item = r_mem[r_rp];
    assign wr     = i_wr && !o_full;
    assign rd     = pop && !empty;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

[design/barometric_sensor_compensation_core.sv]
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_core: pressure sensor compensation
// Turns raw temperature and pressure readings into tenths of a degree and
// pascals with the integer datasheet formulas.
//
//   Channel   Signals                             Beat
//   input     push, full, i_in_data               raw temperature and pressure
//   result    empty, pop, o_out_data              compensated values and flags
//   config    i_cfg_we, i_cfg_idx, i_cfg_data     one register write
//
// One beat is accepted per cycle while full is low, and one result leaves per
// cycle while pop is high and empty is low. The datapath has 78 stages (two
// 32-stage divider pipelines and 14 arithmetic stages), and each result also
// passes through both queues. Reset clears the queues and valid bits;
// oversampling resets to 1 and the coefficients to zero. When the result queue
// is full and a finished beat is waiting, the datapath holds, and the input
// queue takes up to two more beats before full rises.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  bsc_pkg::t_in                      i_in_data,
    output logic                              empty,
    input  logic                              pop,
    output bsc_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bsc_pkg::*;

    t_cfg  r_cfg;
    logic  f_valid;
    t_work f_work;
    logic  b_take;
    logic  b_valid;
    t_out  b_res;
    logic  q_full;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.oss    <= 2'd1;
            r_cfg.ac123  <= '0;
            r_cfg.ac456  <= '0;
            r_cfg.b12    <= '0;
            r_cfg.mbmcmd <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OSS:    r_cfg.oss    <= i_cfg_data[1:0];
                CFG_AC123:  r_cfg.ac123  <= i_cfg_data[47:0];
                CFG_AC456:  r_cfg.ac456  <= i_cfg_data[47:0];
                CFG_B12:    r_cfg.b12    <= i_cfg_data[31:0];
                CFG_MBMCMD: r_cfg.mbmcmd <= i_cfg_data[47:0];
                default: begin
                end
            endcase
        end
    end

    bsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .push      (push),
        .i_in_data (i_in_data),
        .full      (full),
        .o_valid   (f_valid),
        .o_work    (f_work),
        .i_take    (b_take)
    );

    bsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (f_valid),
        .i_work      (f_work),
        .o_take      (b_take),
        .o_res_valid (b_valid),
        .o_res       (b_res),
        .i_res_full  (q_full)
    );

    bsc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (b_valid),
        .i_item  (b_res),
        .o_full  (q_full),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_out_data)
    );

endmodule

[tb/sv/barometric_sensor_compensation_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_core_tb: self-checking bench of the core
// Walks a directed table of raw readings under several calibration sets, then
// random readings, with random idling on both queue sides. Every result beat
// is checked against an in-bench model of the integer compensation formulas.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_core_tb;
    import bsc_pkg::*;

    localparam int MAX_CYCLES = 600000;
    localparam int DRAIN_WAIT = 120;

    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    logic          full;
    t_in           in_beat;
    logic          empty;
    logic          pop;
    t_out          out_beat;
    logic          cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the configuration registers.
    logic [1:0]  sh_oss;
    logic [47:0] sh_ac123;
    logic [47:0] sh_ac456;
    logic [31:0] sh_b12;
    logic [47:0] sh_mbmcmd;

    t_out pending_results[$];
    int   errors;
    int   cycles;
    bit   quiet_push;
    bit   quiet_pop;

    barometric_sensor_compensation_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_data (in_beat),
        .empty     (empty),
        .pop       (pop),
        .o_out_data(out_beat),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Arithmetic shift and truncating division on 32-bit words.
    function automatic logic [31:0] ashr(input logic [31:0] v, input int n);
        logic signed [31:0] s;
        s = v;
        return s >>> n;
    endfunction

    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    function automatic bit is_bad(input logic [15:0] w);
        return (w == 16'h0000) || (w == 16'hFFFF);
    endfunction

    // Compensated temperature and pressure for one raw reading.
    function automatic t_out compensate(input t_in r);
        t_out o;
        int oss;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, bsq, dv, p, tmp;
        bit dz;
        bit cb;
        oss = sh_oss;
        ac1 = sx(sh_ac123[47:32]); ac2 = sx(sh_ac123[31:16]); ac3 = sx(sh_ac123[15:0]);
        ac4 = {16'd0, sh_ac456[47:32]}; ac5 = {16'd0, sh_ac456[31:16]};
        ac6 = {16'd0, sh_ac456[15:0]};
        b1 = sx(sh_b12[31:16]); b2 = sx(sh_b12[15:0]);
        mc = sx(sh_mbmcmd[31:16]); md = sx(sh_mbmcmd[15:0]);
        ut = {16'd0, r.raw_temperature};
        up = {8'd0, r.raw_pressure} >> (8 - oss);
        cb = is_bad(sh_ac123[47:32]) || is_bad(sh_ac123[31:16]) || is_bad(sh_ac123[15:0])
          || is_bad(sh_ac456[47:32]) || is_bad(sh_ac456[31:16]) || is_bad(sh_ac456[15:0])
          || is_bad(sh_mbmcmd[47:32]) || is_bad(sh_mbmcmd[31:16])
          || is_bad(sh_mbmcmd[15:0]) || is_bad(sh_b12[31:16]) || is_bad(sh_b12[15:0]);
        dz = 1'b0;
        // Temperature.
        x1 = ashr((ut - ac6) * ac5, 15);
        dv = x1 + md;
        if (dv == 32'd0) begin
            dz = 1'b1;
            x2 = 32'd0;
        end else begin
            x2 = div_trunc(mc << 11, dv);
        end
        b5  = x1 + x2;
        tmp = ashr(b5 + 32'd8, 4);
        // Pressure.
        b6  = b5 - 32'd4000;
        bsq = ashr(b6 * b6, 12);
        x1  = ashr(b2 * bsq, 11);
        x2  = ashr(ac2 * b6, 11);
        x3  = x1 + x2;
        b3  = ashr(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
        x1  = ashr(ac3 * b6, 13);
        x2  = ashr(b1 * bsq, 16);
        x3  = ashr(x1 + x2 + 32'd2, 2);
        b4  = (ac4 * (x3 + 32'd32768)) >> 15;
        b7  = (up - b3) * (32'd50000 >> oss);
        if (b4 == 32'd0) begin
            dz = 1'b1;
            p  = 32'd0;
        end else if (!b7[31]) begin
            p = (b7 << 1) / b4;
        end else begin
            p = (b7 / b4) << 1;
        end
        x1 = ashr(p, 8) * ashr(p, 8);
        x1 = ashr(x1 * 32'd3038, 16);
        x2 = ashr(32'hFFFF_E343 * p, 16);
        p  = p + ashr(x1 + x2 + 32'd3791, 4);
        o.temperature_tenths = dz ? 32'd0 : tmp;
        o.pressure_pa        = dz ? 32'd0 : p;
        o.divide_error       = dz;
        o.calibration_bad    = cb;
        return o;
    endfunction

    // Register write while idle; the shadow copy follows.
    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_OSS:    sh_oss    = val[1:0];
            CFG_AC123:  sh_ac123  = val;
            CFG_AC456:  sh_ac456  = val;
            CFG_B12:    sh_b12    = val[31:0];
            CFG_MBMCMD: sh_mbmcmd = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [1:0] oss, input logic [47:0] a,
                             input logic [47:0] b, input logic [31:0] c,
                             input logic [47:0] d);
        write_reg(CFG_OSS, {46'd0, oss});
        write_reg(CFG_AC123, a);
        write_reg(CFG_AC456, b);
        write_reg(CFG_B12, {16'd0, c});
        write_reg(CFG_MBMCMD, d);
    endtask

    // Stop sending, then wait until every result has come back.
    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Send one beat; optionally a known expectation is checked against the model's.
    task automatic send(input t_in r, input bit known, input t_out fixed);
        t_out e;
        while (!quiet_push && ($urandom_range(99) < 31)) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        in_beat <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        e = compensate(r);
        if (known && (e != fixed)) begin
            $display("%0t: table row disagrees: table %h model %h", $time, fixed, e);
            errors++;
        end
        pending_results.push_back(e);
    endtask

    // Result side: random pop, compare each accepted beat.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, out_beat);
                    errors++;
                end else begin
                    e = pending_results.pop_front();
                    if (out_beat.temperature_tenths !== e.temperature_tenths)
                        $display("%0t: temperature exp %0d got %0d", $time,
                                 e.temperature_tenths, out_beat.temperature_tenths);
                    if (out_beat.pressure_pa !== e.pressure_pa)
                        $display("%0t: pressure exp %0d got %0d", $time,
                                 e.pressure_pa, out_beat.pressure_pa);
                    if (out_beat.divide_error !== e.divide_error)
                        $display("%0t: divide_error exp %b got %b", $time,
                                 e.divide_error, out_beat.divide_error);
                    if (out_beat.calibration_bad !== e.calibration_bad)
                        $display("%0t: calibration_bad exp %b got %b", $time,
                                 e.calibration_bad, out_beat.calibration_bad);
                    if (out_beat !== e) errors++;
                end
            end
            pop <= quiet_pop || ($urandom_range(99) >= 31);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Directed table: raw readings, and a typed expectation where obvious.
    typedef struct {
        logic [15:0] ut;
        logic [23:0] up;
        bit          known;
        t_out        res;
    } t_row;

    t_row rows[$];

    function automatic t_row mk(input logic [15:0] ut, input logic [23:0] up);
        t_row r;
        r.ut = ut; r.up = up; r.known = 1'b0; r.res = '0;
        return r;
    endfunction

    // Typical calibration data from the sensor sheet.
    localparam logic [47:0] TYP_AC123  = {16'd408, -16'sd72, -16'sd14383};
    localparam logic [47:0] TYP_AC456  = {16'd32741, 16'd32757, 16'd23153};
    localparam logic [31:0] TYP_B12    = {16'd6190, 16'd4};
    localparam logic [47:0] TYP_MBMCMD = {-16'sd32768, -16'sd8711, 16'd2868};

    task automatic run_table();
        t_in r;
        foreach (rows[i]) begin
            r.raw_temperature = rows[i].ut;
            r.raw_pressure    = rows[i].up;
            send(r, rows[i].known, rows[i].res);
        end
        rows.delete();
    endtask

    initial begin
        t_in r;
        t_row w;
        logic [47:0] a, b, d;
        logic [31:0] c;
        errors = 0; cycles = 0;
        quiet_push = 1'b0; quiet_pop = 1'b0;
        i_rst_n = 1'b0; push = 1'b0; pop = 1'b0; in_beat = '0;
        cfg_we = 1'b0; cfg_idx = CFG_OSS; cfg_data = '0;
        sh_oss = 2'd1; sh_ac123 = '0; sh_ac456 = '0; sh_b12 = '0; sh_mbmcmd = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset all coefficients are zero: both divisors vanish.
        w = mk(16'd0, 24'd0);
        w.known = 1'b1; w.res = '{32'sd0, 32'sd0, 1'b1, 1'b1};
        rows.push_back(w);
        w = mk(16'hFFFF, 24'hFFFFFF);
        w.known = 1'b1; w.res = '{32'sd0, 32'sd0, 1'b1, 1'b1};
        rows.push_back(w);
        run_table();
        drain();

        // Typical calibration at each oversampling, field extremes.
        for (int o = 0; o < 4; o++) begin
            write_all(o[1:0], TYP_AC123, TYP_AC456, TYP_B12, TYP_MBMCMD);
            rows.push_back(mk(16'd27898, 24'd23843 << 8));
            rows.push_back(mk(16'd0, 24'd0));
            rows.push_back(mk(16'hFFFF, 24'hFFFFFF));
            rows.push_back(mk(16'h8000, 24'h800000));
            rows.push_back(mk(16'h7FFF, 24'h7FFFFF));
            run_table();
            drain();
        end

        // Extreme coefficients: all ones, then most negative and most positive words.
        write_all(2'd3, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                  48'hFFFF_FFFF_FFFF);
        rows.push_back(mk(16'd0, 24'hFFFFFF));
        rows.push_back(mk(16'hFFFF, 24'd0));
        write_reg(CFG_AC123, 48'h8000_8000_8000);
        write_reg(CFG_B12, 32'h8000_7FFF);
        write_reg(CFG_MBMCMD, 48'h7FFF_7FFF_8000);
        rows.push_back(mk(16'h1234, 24'hABCDEF));
        rows.push_back(mk(16'hFFFF, 24'hFFFFFF));
        run_table();
        drain();

        // Random part: mostly plausible calibration sets, some wild ones.
        for (int phase = 0; phase < 12; phase++) begin
            if (phase % 3 == 0) begin
                a = 48'({$urandom(), $urandom()});
                b = 48'({$urandom(), $urandom()});
                c = $urandom();
                d = 48'({$urandom(), $urandom()});
            end else begin
                a = {16'($urandom_range(200, 9000)), 16'(-$urandom_range(1, 1500)),
                     16'(-$urandom_range(10000, 16000))};
                b = {16'($urandom_range(30000, 36000)), 16'($urandom_range(20000, 33000)),
                     16'($urandom_range(15000, 25000))};
                c = {16'($urandom_range(5000, 7000)), 16'($urandom_range(1, 100))};
                d = {16'h8000, 16'(-$urandom_range(8000, 12000)),
                     16'($urandom_range(2000, 3000))};
            end
            write_all(2'($urandom_range(3)), a, b, c, d);
            quiet_push = (phase == 5);
            quiet_pop  = (phase == 5);
            for (int k = 0; k < 150; k++) begin
                if (phase % 3 != 0 && $urandom_range(9) < 8) begin
                    r.raw_temperature = 16'($urandom_range(20000, 36000));
                    r.raw_pressure    = 24'($urandom_range(18000, 30000)) << 8
                                        | 24'($urandom_range(255));
                end else begin
                    r.raw_temperature = 16'($urandom());
                    r.raw_pressure    = 24'($urandom());
                end
                send(r, 1'b0, '0);
                if (k == 75 && phase == 7) begin
                    // Hold the sender until the pipeline has run dry.
                    push <= 1'b0;
                    @(posedge i_clk);
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
